// File: hw/rtl/cuhi_pkg.sv
// shared types and constants for the cubic hermite interpolator
`timescale 1ns / 1ps
package cuhi_pkg;

    typedef logic signed [31:0] q16_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               ready;
        logic               sat;
    } res_t;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    localparam int T_FRAC = 30;
    localparam int ACC_W  = 100;
    localparam int RND_SH = 46;

endpackage

// File: hw/rtl/cuhi_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cuhi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/cuhi_front.sv
// front end: accepts items, writes the knot table, queues queries
`timescale 1ns / 1ps
module cuhi_front #(
    parameter int MAX_KNOTS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       mode,
    input  cuhi_pkg::q16_t                   knot_position,
    input  cuhi_pkg::q16_t                   knot_value,
    input  cuhi_pkg::q16_t                   knot_slope,
    input  cuhi_pkg::q16_t                   query_position,
    input  logic                             back_busy,
    output logic                             tab_we,
    output logic [$clog2(MAX_KNOTS)-1:0]     tab_waddr,
    output cuhi_pkg::q16_t                   tab_pos,
    output logic [63:0]                      tab_vs,
    output logic                             qv,
    input  logic                             q_pop,
    output cuhi_pkg::q16_t                   q_pos,
    output logic [$clog2(MAX_KNOTS+1)-1:0]   q_count
);
    import cuhi_pkg::*;

    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int IW = $clog2(MAX_KNOTS);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    q16_t          qpos_reg [2];
    logic [CW-1:0] qcnt_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          is_tab, is_query, accept, push;

    assign is_tab   = (mode == MODE_CLEAR) || (mode == MODE_APPEND);
    assign is_query = (mode == MODE_QUERY);
    // table changes wait until every queued query has read the table
    assign in_stall = (is_tab && ((fill_reg != 2'd0) || back_busy))
                   || (is_query && (fill_reg == 2'd2));
    assign accept   = in_valid && !in_stall;
    assign push     = accept && is_query;

    assign tab_we    = accept && (mode == MODE_APPEND) && (count_reg < CW'(MAX_KNOTS));
    assign tab_waddr = count_reg[IW-1:0];
    assign tab_pos   = knot_position;
    assign tab_vs    = {knot_value, knot_slope};

    assign qv      = (fill_reg != 2'd0);
    assign q_pos   = qpos_reg[rptr_reg];
    assign q_count = qcnt_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (accept && (mode == MODE_CLEAR))
        begin
            count_next = '0;
        end
        else if (tab_we)
        begin
            count_next = count_reg + CW'(1);
        end
        fill_next = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fill_reg  <= '0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fill_reg  <= fill_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            qpos_reg[wptr_reg] <= query_position;
            qcnt_reg[wptr_reg] <= count_reg;
        end
    end
endmodule

// File: hw/rtl/cuhi_back.sv
// back end: segment scan, serial divide, hermite evaluation, output register
`timescale 1ns / 1ps
module cuhi_back #(
    parameter int MAX_KNOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           qv,
    output logic                           q_pop,
    input  cuhi_pkg::q16_t                 q_pos,
    input  logic [$clog2(MAX_KNOTS+1)-1:0] q_count,
    output logic                           busy,
    output logic [$clog2(MAX_KNOTS)-1:0]   raddr,
    input  cuhi_pkg::q16_t                 pos_rd,
    input  logic [63:0]                    vs_rd,
    output logic                           out_valid,
    input  logic                           out_stall,
    output cuhi_pkg::res_t                 res
);
    import cuhi_pkg::*;

    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int IW = $clog2(MAX_KNOTS);
    localparam int RW = ACC_W - RND_SH;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_LAST   = 15'b000000000000010,
        S_FIRST  = 15'b000000000000100,
        S_SECOND = 15'b000000000001000,
        S_SCAN   = 15'b000000000010000,
        S_FIXA   = 15'b000000000100000,
        S_FIXB   = 15'b000000001000000,
        S_VR0    = 15'b000000010000000,
        S_VR1    = 15'b000000100000000,
        S_VR2    = 15'b000001000000000,
        S_DSET   = 15'b000010000000000,
        S_DIV    = 15'b000100000000000,
        S_MUL    = 15'b001000000000000,
        S_ACC    = 15'b010000000000000,
        S_FIN    = 15'b100000000000000
    } state_t;

    localparam logic [3:0] OP_TT   = 4'd0;
    localparam logic [3:0] OP_T2T  = 4'd1;
    localparam logic [3:0] OP_DX0  = 4'd2;
    localparam logic [3:0] OP_DX1  = 4'd3;
    localparam logic [3:0] OP_Y0   = 4'd4;
    localparam logic [3:0] OP_Y1   = 4'd5;
    localparam logic [3:0] OP_M0LO = 4'd6;
    localparam logic [3:0] OP_M0HI = 4'd7;
    localparam logic [3:0] OP_M1LO = 4'd8;
    localparam logic [3:0] OP_M1HI = 4'd9;

    state_t state_reg;
    state_t state_next;

    q16_t                q_reg, xlast_reg, xcur_reg, xf0_reg, xf1_reg, x0_reg, x1_reg;
    q16_t                y0_reg, d0_reg, y1_reg, d1_reg;
    logic [CW-1:0]       n_reg;
    logic [IW-1:0]       i_reg, idx_reg;
    logic                short_reg;
    logic signed [32:0]  dx_reg;
    logic signed [32:0]  num_reg;
    logic [32:0]         dabs_reg, rem_reg;
    logic [29:0]         quo_reg;
    logic [4:0]          dcnt_reg;
    logic [30:0]         t_reg, t2_reg;
    logic signed [31:0]  h00_reg, h10_reg, h01_reg, h11_reg;
    logic signed [64:0]  m0_reg, m1_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [65:0]  p_reg;
    logic [3:0]          k_reg;

    logic signed [32:0]  opa, opb;
    logic                hit, past_end, at_end;
    logic [CW:0]         i2;
    logic signed [33:0]  nn;
    logic [33:0]         rem2;
    logic                ge;
    logic [30:0]         t3n;
    logic signed [33:0]  h00n, h10n, h01n, h11n;
    logic signed [ACC_W-1:0] pe;
    logic signed [RW-1:0] rnd;
    logic                sat_hi, sat_lo, load_out;

    assign busy  = (state_reg != S_IDLE);
    assign q_pop = (state_reg == S_IDLE) && qv;

    assign hit      = (q_reg >= xcur_reg) && (q_reg <= pos_rd);
    assign past_end = (q_reg > xlast_reg);
    assign i2       = (CW+1)'(i_reg) + (CW+1)'(2);
    assign at_end   = (i2 == (CW+1)'(n_reg));

    assign nn   = dx_reg[32] ? -34'(num_reg) : 34'(num_reg);
    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, dabs_reg});

    assign pe  = ACC_W'(p_reg);
    assign rnd = RW'(acc_reg >>> RND_SH);
    assign sat_hi = (rnd > RW'(64'sh7FFFFFFF));
    assign sat_lo = (rnd < -RW'(64'sh80000000));
    assign load_out = (state_reg == S_FIN) && (!out_valid || !out_stall);

    // basis from t, t2 and the fresh t3
    always_comb
    begin
        t3n  = p_reg[60:30];
        h00n = 34'sd2 * 34'($signed({1'b0, t3n})) - 34'sd3 * 34'($signed({1'b0, t2_reg}))
             + 34'sh40000000;
        h10n = 34'($signed({1'b0, t3n})) - 34'sd2 * 34'($signed({1'b0, t2_reg}))
             + 34'($signed({1'b0, t_reg}));
        h01n = 34'sd3 * 34'($signed({1'b0, t2_reg})) - 34'sd2 * 34'($signed({1'b0, t3n}));
        h11n = 34'($signed({1'b0, t3n})) - 34'($signed({1'b0, t2_reg}));
    end

    always_comb
    begin
        case (k_reg)
            OP_TT:   begin opa = {2'b0, t_reg};         opb = {2'b0, t_reg}; end
            OP_T2T:  begin opa = {2'b0, t2_reg};        opb = {2'b0, t_reg}; end
            OP_DX0:  begin opa = dx_reg;                opb = {d0_reg[31], d0_reg}; end
            OP_DX1:  begin opa = dx_reg;                opb = {d1_reg[31], d1_reg}; end
            OP_Y0:   begin opa = {y0_reg[31], y0_reg};  opb = {h00_reg[31], h00_reg}; end
            OP_Y1:   begin opa = {y1_reg[31], y1_reg};  opb = {h01_reg[31], h01_reg}; end
            OP_M0LO: begin opa = {1'b0, m0_reg[31:0]};  opb = {h10_reg[31], h10_reg}; end
            OP_M0HI: begin opa = m0_reg[64:32];         opb = {h10_reg[31], h10_reg}; end
            OP_M1LO: begin opa = {1'b0, m1_reg[31:0]};  opb = {h11_reg[31], h11_reg}; end
            OP_M1HI: begin opa = m1_reg[64:32];         opb = {h11_reg[31], h11_reg}; end
            default: begin opa = '0;                    opb = '0; end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_LAST:   raddr = IW'(n_reg - CW'(1));
            S_SECOND: raddr = IW'(1);
            S_SCAN:   raddr = i2[IW-1:0];
            S_FIXA:   raddr = IW'(n_reg - CW'(2));
            S_VR0:    raddr = idx_reg;
            S_VR1:    raddr = IW'((CW+1)'(idx_reg) + (CW+1)'(1));
            default:  raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (qv) state_next = (q_count < CW'(2)) ? S_FIN : S_LAST;
            S_LAST:   state_next = S_FIRST;
            S_FIRST:  state_next = S_SECOND;
            S_SECOND: state_next = S_SCAN;
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_VR0;
                end
                else if (past_end)
                begin
                    state_next = S_FIXA;
                end
                else if (at_end)
                begin
                    state_next = S_VR0;
                end
            end
            S_FIXA:   state_next = S_FIXB;
            S_FIXB:   state_next = S_VR0;
            S_VR0:    state_next = S_VR1;
            S_VR1:    state_next = S_VR2;
            S_VR2:    state_next = S_DSET;
            S_DSET:
            begin
                if ((dx_reg == '0) || (nn <= 34'sd0) || (nn >= $signed({1'b0, dabs_reg})))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:    if (dcnt_reg == 5'd29) state_next = S_MUL;
            S_MUL:    state_next = S_ACC;
            S_ACC:    state_next = (k_reg == OP_M1HI) ? S_FIN : S_MUL;
            S_FIN:    if (load_out) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                q_reg     <= q_pos;
                n_reg     <= q_count;
                short_reg <= (q_count < CW'(2));
            end
            S_FIRST:  xlast_reg <= pos_rd;
            S_SECOND:
            begin
                xcur_reg <= pos_rd;
                xf0_reg  <= pos_rd;
                i_reg    <= '0;
            end
            S_SCAN:
            begin
                if (i_reg == '0)
                begin
                    xf1_reg <= pos_rd;
                end
                if (hit)
                begin
                    idx_reg <= i_reg;
                    x0_reg  <= xcur_reg;
                    x1_reg  <= pos_rd;
                end
                else if (past_end)
                begin
                    idx_reg <= IW'(n_reg - CW'(2));
                end
                else if (at_end)
                begin
                    // no segment holds the query: fall back to segment 0
                    idx_reg <= '0;
                    x0_reg  <= xf0_reg;
                    x1_reg  <= (i_reg == '0) ? pos_rd : xf1_reg;
                end
                else
                begin
                    i_reg    <= i_reg + IW'(1);
                    xcur_reg <= pos_rd;
                end
            end
            S_FIXB:
            begin
                x0_reg <= pos_rd;
                x1_reg <= xlast_reg;
            end
            S_VR1:
            begin
                y0_reg  <= vs_rd[63:32];
                d0_reg  <= vs_rd[31:0];
                dx_reg  <= 33'(x1_reg) - 33'(x0_reg);
                num_reg <= 33'(q_reg) - 33'(x0_reg);
            end
            S_VR2:
            begin
                y1_reg   <= vs_rd[63:32];
                d1_reg   <= vs_rd[31:0];
                dabs_reg <= dx_reg[32] ? 33'(-34'(dx_reg)) : 33'(dx_reg);
                acc_reg  <= ACC_W'(1) <<< (RND_SH - 1);
            end
            S_DSET:
            begin
                k_reg    <= OP_TT;
                rem_reg  <= nn[32:0];
                quo_reg  <= '0;
                dcnt_reg <= '0;
                if ((dx_reg == '0) || (nn <= 34'sd0))
                begin
                    t_reg <= '0;
                end
                else
                begin
                    t_reg <= 31'h40000000;
                end
            end
            S_DIV:
            begin
                rem_reg  <= ge ? 33'(rem2 - {1'b0, dabs_reg}) : rem2[32:0];
                quo_reg  <= {quo_reg[28:0], ge};
                dcnt_reg <= dcnt_reg + 5'd1;
                if (dcnt_reg == 5'd29)
                begin
                    t_reg <= {1'b0, quo_reg[28:0], ge};
                end
            end
            S_MUL:    p_reg <= opa * opb;
            S_ACC:
            begin
                k_reg <= k_reg + 4'd1;
                case (k_reg)
                    OP_TT:   t2_reg <= p_reg[60:30];
                    OP_T2T:
                    begin
                        h00_reg <= 32'(h00n);
                        h10_reg <= 32'(h10n);
                        h01_reg <= 32'(h01n);
                        h11_reg <= 32'(h11n);
                    end
                    OP_DX0:  m0_reg <= p_reg[64:0];
                    OP_DX1:  m1_reg <= p_reg[64:0];
                    OP_Y0, OP_Y1:     acc_reg <= acc_reg + (pe <<< 16);
                    OP_M0LO, OP_M1LO: acc_reg <= acc_reg + pe;
                    OP_M0HI, OP_M1HI: acc_reg <= acc_reg + (pe <<< 32);
                    default: acc_reg <= acc_reg;
                endcase
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    if (short_reg)
                    begin
                        res <= '{value: '0, ready: 1'b0, sat: 1'b0};
                    end
                    else if (sat_hi)
                    begin
                        res <= '{value: 32'sh7FFFFFFF, ready: 1'b1, sat: 1'b1};
                    end
                    else if (sat_lo)
                    begin
                        res <= '{value: 32'sh80000000, ready: 1'b1, sat: 1'b1};
                    end
                    else
                    begin
                        res <= '{value: 32'(rnd), ready: 1'b1, sat: 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

// File: hw/rtl/piecewise_cubic_hermite_interp.sv
// top level of the piecewise cubic hermite interpolator
`timescale 1ns / 1ps
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | mode, knot_position, knot_value, knot_slope, query_position
//  output  | out_valid | out_stall | interpolated_value, table_ready, saturated
//
//  clear and append are accepted once the query queue is empty and the back end idle
//  a query on a table of at least two knots goes through the serial segment scan over the
//  position ram (one knot per cycle), a restoring divide when the query lies inside the
//  segment, and ten passes through one shared 33x33 multiplier
//  a two entry queue lets the front keep taking queries while the back end works
//  rst_n clears the knot count, the queue and the output valid flag; table rams are not cleared
//  a stalled result sits in the output register while the next query is evaluated
module piecewise_cubic_hermite_interp #(
    parameter int MAX_KNOTS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  cuhi_pkg::q16_t        knot_position,
    input  cuhi_pkg::q16_t        knot_value,
    input  cuhi_pkg::q16_t        knot_slope,
    input  cuhi_pkg::q16_t        query_position,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cuhi_pkg::q16_t        interpolated_value,
    output logic                  table_ready,
    output logic                  saturated
);
    import cuhi_pkg::*;

    localparam int CW = $clog2(MAX_KNOTS + 1);
    localparam int IW = $clog2(MAX_KNOTS);

    // front to ram write side
    logic          tab_we;
    logic [IW-1:0] tab_waddr;
    q16_t          tab_pos;
    logic [63:0]   tab_vs;

    // query queue head
    logic          qv, q_pop;
    q16_t          q_pos;
    logic [CW-1:0] q_count;

    // back end read side
    logic          back_busy;
    logic [IW-1:0] raddr;
    logic [31:0]   pos_rd;
    logic [63:0]   vs_rd;
    res_t          res;

    cuhi_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .knot_position  (knot_position),
        .knot_value     (knot_value),
        .knot_slope     (knot_slope),
        .query_position (query_position),
        .back_busy      (back_busy),
        .tab_we         (tab_we),
        .tab_waddr      (tab_waddr),
        .tab_pos        (tab_pos),
        .tab_vs         (tab_vs),
        .qv             (qv),
        .q_pop          (q_pop),
        .q_pos          (q_pos),
        .q_count        (q_count)
    );

    // positions: scanned one entry per cycle
    cuhi_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_pos_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_pos),
        .raddr (raddr),
        .rdata (pos_rd)
    );

    // value and slope side by side, read for the two segment ends
    cuhi_ram #(.WIDTH(64), .DEPTH(MAX_KNOTS)) u_vs_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_vs),
        .raddr (raddr),
        .rdata (vs_rd)
    );

    cuhi_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qv        (qv),
        .q_pop     (q_pop),
        .q_pos     (q_pos),
        .q_count   (q_count),
        .busy      (back_busy),
        .raddr     (raddr),
        .pos_rd    (pos_rd),
        .vs_rd     (vs_rd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign interpolated_value = res.value;
    assign table_ready        = res.ready;
    assign saturated          = res.sat;
endmodule

// File: hw/rtl/cuhi_checker.sv
// port level checker for the interpolator, bound to the top level
`timescale 1ns / 1ps
module cuhi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] interpolated_value,
    input logic        table_ready,
    input logic        saturated
);
    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(interpolated_value) && $stable(table_ready)
            && $stable(saturated))
        else $error("result changed while stalled");

    // a short table answers zero and never saturates
    a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !table_ready |-> interpolated_value == 32'h0 && !saturated)
        else $error("short table result not zero");

    // saturation only at the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> interpolated_value == 32'h7FFFFFFF
            || interpolated_value == 32'h80000000)
        else $error("saturated result not at a limit");
endmodule

bind piecewise_cubic_hermite_interp cuhi_checker u_cuhi_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .interpolated_value (interpolated_value),
    .table_ready        (table_ready),
    .saturated          (saturated)
);

// File: tb/piecewise_cubic_hermite_interp_checker.sv
// transfer monitor, spline predictor and result comparison for the hermite interpolator
`timescale 1ns / 1ps
module piecewise_cubic_hermite_interp_checker #(
    parameter int MAX_KNOTS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  logic [1:0]     mode,
    input  cuhi_pkg::q16_t knot_position,
    input  cuhi_pkg::q16_t knot_value,
    input  cuhi_pkg::q16_t knot_slope,
    input  cuhi_pkg::q16_t query_position,
    input  logic           out_valid,
    input  logic           out_stall,
    input  cuhi_pkg::q16_t interpolated_value,
    input  logic           table_ready,
    input  logic           saturated,
    output int             fail_count,
    output int             results_pending,
    output int             results_seen
);
    import cuhi_pkg::*;

    q16_t knot_x [MAX_KNOTS];
    q16_t knot_y [MAX_KNOTS];
    q16_t knot_d [MAX_KNOTS];
    int   knots_held;
    res_t spline_results [$];

    function automatic logic signed [127:0] wide_mul(input longint a, input longint b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        wa = a;
        wb = b;
        return wa * wb;
    endfunction

    // hermite evaluation of the held table at one position
    function automatic res_t spline_at(input q16_t q);
        int                  seg;
        longint              x0, x1, dx, num, d, t, t2, t3, h00, h10, h01, h11;
        logic signed [127:0] acc, rounded;
        res_t                r;
        r = '0;
        if (knots_held < 2)
            return r;
        seg = 0;
        for (int i = 0; i + 1 < knots_held; i++)
        begin
            if (q >= knot_x[i] && q <= knot_x[i + 1])
            begin
                seg = i;
                break;
            end
            if (q > knot_x[knots_held - 1])
            begin
                seg = knots_held - 2;
                break;
            end
        end
        x0  = knot_x[seg];
        x1  = knot_x[seg + 1];
        dx  = x1 - x0;
        num = longint'(q) - x0;
        d   = dx;
        if (dx == 0)
            t = 0;
        else
        begin
            if (d < 0)
            begin
                d   = -d;
                num = -num;
            end
            if (num <= 0)
                t = 0;
            else if (num >= d)
                t = longint'(1) << T_FRAC;
            else
                t = (num << T_FRAC) / d;
        end
        t2  = (t * t) >>> T_FRAC;
        t3  = (t2 * t) >>> T_FRAC;
        h00 = 2 * t3 - 3 * t2 + (longint'(1) << T_FRAC);
        h10 = t3 - 2 * t2 + t;
        h01 = -2 * t3 + 3 * t2;
        h11 = t3 - t2;
        acc = (wide_mul(knot_y[seg], h00) <<< 16)
            + wide_mul(dx * longint'(knot_d[seg]), h10)
            + (wide_mul(knot_y[seg + 1], h01) <<< 16)
            + wide_mul(dx * longint'(knot_d[seg + 1]), h11)
            + (128'sd1 <<< 45);
        rounded = acc >>> RND_SH;
        r.ready = 1'b1;
        if (rounded > wide_mul(64'sd2147483647, 64'sd1))
        begin
            r.value = 32'sh7fffffff;
            r.sat   = 1'b1;
        end
        else if (rounded < wide_mul(-64'sd2147483648, 64'sd1))
        begin
            r.value = 32'sh80000000;
            r.sat   = 1'b1;
        end
        else
            r.value = rounded[31:0];
        return r;
    endfunction

    assign results_pending = spline_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            knots_held   <= 0;
            fail_count   <= 0;
            results_seen <= 0;
            spline_results.delete();
        end
        else
        begin
            // input transfer: update table copy or predict a result
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_CLEAR)
                    knots_held <= 0;
                else if (mode == MODE_APPEND)
                begin
                    if (knots_held < MAX_KNOTS)
                    begin
                        knot_x[knots_held] <= knot_position;
                        knot_y[knots_held] <= knot_value;
                        knot_d[knots_held] <= knot_slope;
                        knots_held <= knots_held + 1;
                    end
                end
                else if (mode == MODE_QUERY)
                    spline_results.push_back(spline_at(query_position));
            end
            // output transfer: compare against oldest prediction
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (spline_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result value=%h ready=%b sat=%b",
                                 interpolated_value, table_ready, saturated);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = spline_results.pop_front();
                    if (want.value !== interpolated_value || want.ready !== table_ready
                        || want.sat !== saturated)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected value=%h ready=%b sat=%b, got %h %b %b",
                                     want.value, want.ready, want.sat,
                                     interpolated_value, table_ready, saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/piecewise_cubic_hermite_interp_test.sv
// stimulus, clock, reset and verdict for the hermite interpolator
`timescale 1ns / 1ps
module piecewise_cubic_hermite_interp_test;
    import cuhi_pkg::*;

    localparam int MAX_KNOTS  = 64;
    localparam int CYCLE_CAP  = 900000;
    localparam int HOLD_LEN   = 600;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    logic [1:0]     mode = MODE_CLEAR;
    q16_t           knot_position = '0;
    q16_t           knot_value = '0;
    q16_t           knot_slope = '0;
    q16_t           query_position = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    q16_t           interpolated_value;
    logic           table_ready;
    logic           saturated;

    int             fail_count, results_pending, results_seen;
    int             cycle_count = 0;
    int             items_sent = 0;
    int             queries_sent = 0;
    int             appends_sent = 0;
    bit             sender_calm = 1'b0;
    bit             receiver_calm = 1'b0;
    bit             hold_request = 1'b0;

    // sorted knot positions of the current random table, for aiming queries
    longint         table_x [$];

    always #4 clk = ~clk;

    piecewise_cubic_hermite_interp #(.MAX_KNOTS(MAX_KNOTS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .knot_position(knot_position), .knot_value(knot_value),
        .knot_slope(knot_slope), .query_position(query_position),
        .out_valid(out_valid), .out_stall(out_stall),
        .interpolated_value(interpolated_value), .table_ready(table_ready),
        .saturated(saturated)
    );

    piecewise_cubic_hermite_interp_checker #(.MAX_KNOTS(MAX_KNOTS)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .knot_position(knot_position), .knot_value(knot_value),
        .knot_slope(knot_slope), .query_position(query_position),
        .out_valid(out_valid), .out_stall(out_stall),
        .interpolated_value(interpolated_value), .table_ready(table_ready),
        .saturated(saturated),
        .fail_count(fail_count), .results_pending(results_pending),
        .results_seen(results_seen)
    );

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request, calm stretch when asked
    initial
    begin
        int held;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // long hold-off so the query queue fills and the input stalls
                out_stall = 1'b1;
                held = 0;
                while (held < HOLD_LEN)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_request = 1'b0;
            end
            out_stall = (!receiver_calm && $urandom_range(99) < 24);
        end
    end

    // one input transfer: optional idle cycles, then hold the payload until accepted
    task automatic send_item(input logic [1:0] m, input q16_t kx, input q16_t ky,
                             input q16_t kd, input q16_t q);
        while (!sender_calm && $urandom_range(99) < 24)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        mode           = m;
        knot_position  = kx;
        knot_value     = ky;
        knot_slope     = kd;
        query_position = q;
        in_valid       = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        items_sent++;
        if (m == MODE_QUERY)
            queries_sent++;
        if (m == MODE_APPEND)
            appends_sent++;
    endtask

    task automatic send_append(input q16_t kx, input q16_t ky, input q16_t kd);
        send_item(MODE_APPEND, kx, ky, kd, $urandom);
    endtask

    task automatic send_query(input q16_t q);
        send_item(MODE_QUERY, $urandom, $urandom, $urandom, q);
    endtask

    function automatic q16_t clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // random ordinate or slope: mostly moderate, sometimes the full range
    function automatic q16_t pick_level();
        if ($urandom_range(99) < 20)
            return $urandom;
        return clip32(longint'($signed($urandom_range(32'h00ffffff))) - 64'sd8388608);
    endfunction

    // fresh table: clear, then a run of knots, mostly ascending
    task automatic build_table();
        int     n;
        longint x;
        longint step;
        bit     shuffled;
        table_x.delete();
        send_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
        case ($urandom_range(9))
            0:       n = $urandom_range(1);
            1:       n = MAX_KNOTS + $urandom_range(4);
            default: n = $urandom_range(2, 10);
        endcase
        shuffled = ($urandom_range(9) == 0);
        x = longint'($signed($urandom)) >>> $urandom_range(0, 8);
        for (int i = 0; i < n; i++)
        begin
            table_x.push_back(x);
            send_append(clip32(shuffled ? longint'($signed($urandom)) : x),
                        pick_level(), pick_level());
            case ($urandom_range(9))
                0:       step = 0;
                1:       step = $urandom;
                default: step = $urandom_range(1, 32'h0004ffff);
            endcase
            x = longint'(clip32(x + step));
        end
    endtask

    // query aimed near the table, with some outliers and exact knots
    function automatic q16_t pick_query();
        longint base;
        if (table_x.size() == 0 || $urandom_range(9) == 0)
            return $urandom;
        base = table_x[$urandom_range(table_x.size() - 1)];
        case ($urandom_range(3))
            0:       return clip32(base);
            1:       return clip32(base - $urandom_range(32'h00040000));
            default: return clip32(base + $urandom_range(32'h00040000));
        endcase
    endfunction

    initial
    begin
        int rounds;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty and single-knot tables answer not ready
        send_item(MODE_CLEAR, '0, '0, '0, '0);
        send_query(32'sh00010000);
        send_append(32'sh00000000, 32'sh00010000, 32'sh00000000);
        send_query(32'sh00000000);
        // extreme knots, queries at both ends and outside
        send_append(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_query(32'sh80000000);
        send_query(32'sh7fffffff);
        send_query(32'sh3fffffff);
        send_item(MODE_CLEAR, '0, '0, '0, '0);
        send_append(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_append(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
        send_query(32'sh00000000);
        send_query(32'sh80000000);
        // unused mode leaves everything alone
        send_item(2'd3, 32'sh12345678, '0, '0, 32'sh00000000);
        send_query(32'sh00000000);
        // zero-length segment and unsorted table
        send_item(MODE_CLEAR, '0, '0, '0, '0);
        send_append(32'sh00010000, 32'sh00020000, 32'sh00010000);
        send_append(32'sh00010000, 32'shfffe0000, 32'shffff0000);
        send_query(32'sh00010000);
        send_append(32'shfff00000, 32'sh00050000, 32'sh00000000);
        send_query(32'sh00008000);
        send_query(32'sh00200000);
        send_query(32'shff000000);

        // random part: fresh tables followed by bursts of queries
        while (items_sent < 670)
        begin
            sender_calm   = (items_sent >= 300 && items_sent < 400);
            receiver_calm = (items_sent >= 420 && items_sent < 500);
            if (!hold_request && items_sent >= 200 && items_sent < 210)
                hold_request = 1'b1;
            if (table_x.size() == 0 || $urandom_range(5) == 0)
                build_table();
            rounds = $urandom_range(1, 8);
            for (int i = 0; i < rounds; i++)
            begin
                if ($urandom_range(29) == 0)
                    send_item(2'd3, $urandom, $urandom, $urandom, $urandom);
                else if ($urandom_range(19) == 0)
                    send_append($urandom, $urandom, $urandom);
                else
                    send_query(pick_query());
            end
        end
        receiver_calm = 1'b0;

        // drain, then allow for a trailing query still in flight
        while (results_pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);

        $display("sent %0d transfers: %0d queries, %0d appends; %0d results checked",
                 items_sent, queries_sent, appends_sent, results_seen);
        $display("covered empty, full, unsorted and zero-length tables, extremes and saturation");
        if (fail_count == 0 && results_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
